// ===== rtl/core/sitdt_pkg.sv =====
// Shared types and constants for the signed integer to decimal text block.
`default_nettype none

package sitdt_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic top_zero;
    logic remain_one;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sitdt_dp.sv =====
// Datapath: magnitude, shift-add-3 decimal register, digit counters and output register.
`default_nettype none

module sitdt_dp import sitdt_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [6:0]                 out_char,
  output logic                       out_last
);

  localparam int MAG_W      = VALUE_BITS + (VALUE_BITS % 2);
  localparam int STEPS      = MAG_W / 2;
  localparam int STEP_W     = $clog2(STEPS);
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int WORK_W     = BCD_W + MAG_W;

  logic [MAG_W-1:0]      mag;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;
  logic [STEP_W-1:0]     step_cnt;
  logic [REM_W-1:0]      remain;
  logic [WORK_W-1:0]     work;
  logic [VALUE_BITS-1:0] abs_value;
  logic [3:0]            top_digit;

  assign abs_value = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
  assign top_digit = bcd[BCD_W-1 -: 4];

  // Two bits of the magnitude enter the decimal register per cycle.
  always_comb begin
    work = {bcd, mag};
    for (int b = 0; b < 2; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work[MAG_W + 4*d +: 4] >= 4'd5) begin
          work[MAG_W + 4*d +: 4] = work[MAG_W + 4*d +: 4] + 4'd3;
        end
      end
      work = {work[WORK_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= MAG_W'(abs_value);
      bcd      <= '0;
      neg      <= value[VALUE_BITS-1];
      step_cnt <= '0;
      remain   <= REM_W'(NUM_DIGITS);
    end else if (cmd.step) begin
      bcd      <= work[WORK_W-1 -: BCD_W];
      mag      <= work[MAG_W-1:0];
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd    <= {bcd[BCD_W-5:0], 4'd0};
      remain <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= CHAR_ZERO + 7'(top_digit);
      out_last <= (remain == REM_W'(1));
    end
  end

  always_comb begin
    sts.last_step  = (step_cnt == STEP_W'(STEPS - 1));
    sts.top_zero   = (top_digit == 4'd0);
    sts.remain_one = (remain == REM_W'(1));
    sts.neg        = neg;
    sts.out_free   = !out_valid || out_ready;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("character loaded over a beat not yet taken");

  a_emit_remain: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (remain != '0))
    else $error("digit emitted with no digits left");

  a_skip_keeps_one: assert property (@(posedge clk) disable iff (rst)
    cmd.skip |-> !sts.remain_one)
    else $error("leading zero skip dropped the final digit");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.emit_digit) && !$past(rst) && out_last |-> (out_char != CHAR_MINUS))
    else $error("last beat carries a minus sign");

endmodule

`default_nettype wire

// ===== rtl/core/sitdt_ctrl.sv =====
// Controller state machine sequencing load, conversion, zero skip and character output.
`default_nettype none

module sitdt_ctrl import sitdt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Leading zeros are dropped, but a lone zero digit stays.
        if (sts.top_zero && !sts.remain_one) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.remain_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_text.sv =====
// Signed integer to decimal ASCII text converter, top level.
//
// Usage: one beat on the s_ channel carries a two's complement integer in the
// low VALUE_BITS bits of s_tdata. The block answers with its decimal text on
// the m_ channel, one character per beat, most significant digit first. A
// negative value starts with '-'. m_tlast marks the final character.
// The input beat is taken in a load step. The magnitude is then converted
// by a shift-add-3 decimal register taking two bits per cycle. The digit
// register, 20 digits for 64 bits, is then walked one digit per cycle while
// the receiver keeps up: leading zeros are dropped and the remaining digits
// leave as characters, after a sign character when negative. The next input
// beat is taken once the last character sits in the output register.
// Reset clears the controller and the output valid; nothing else is kept.
// When the receiver stalls, the current character holds in the output
// register and the controller waits before loading the next character.
`default_nettype none

module signed_int_to_decimal_text import sitdt_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [VALUE_BITS-1:0] value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [6:0] char_code, [7] zero fill
  output logic             m_tlast
);

  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] out_char;

  sitdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitdt_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire
